// ===== hdl/fqkr_pkg.sv =====
`default_nettype none
package fqkr_pkg;

    localparam int HANDLE_W = 16;
    localparam int PID_W    = 16;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] job_handle;
        logic [PID_W-1:0]    job_pid;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [COUNT_W-1:0]  entry_count;
        logic                front_valid;
        logic [HANDLE_W-1:0] front_handle;
        logic [PID_W-1:0]    front_pid;
    } out_word_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
    } entry_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic occupied;   // cell lies below the fill count
        logic write;      // push lands in this cell
        logic pop;        // whole row shifts toward the front
        logic remove;     // keyed removal in progress
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/fqkr_cell.sv =====
`default_nettype none
module fqkr_cell
(
    input  wire logic                      clk,
    input  wire fqkr_pkg::cell_ctrl_t      ctrl,
    input  wire fqkr_pkg::entry_t          new_entry,
    input  wire fqkr_pkg::entry_t          nbr_entry,
    input  wire logic [fqkr_pkg::PID_W-1:0] key,
    input  wire logic                      found_in,
    output fqkr_pkg::entry_t               entry,
    output logic                           found_out
);

    fqkr_pkg::entry_t entry_reg;
    fqkr_pkg::entry_t entry_next;
    logic             hit;
    logic             shift;

    // a match here or at any older cell pulls this cell from its younger neighbor
    assign hit       = ctrl.occupied && (entry_reg.pid == key);
    assign found_out = found_in || hit;
    assign shift     = ctrl.pop || (ctrl.remove && found_out);

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = nbr_entry;
        end
        else if (ctrl.write)
        begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ===== hdl/fifo_queue_with_keyed_removal.sv =====
// FIFO of job entries (handle + pid) with removal of the oldest entry by pid.
//
// Command channel: drive request and raise start; the word is taken at the
// rising edge where start is high and busy is low. busy never rises, so a
// command can be issued every cycle.
// Result channel: done pulses for one cycle, in the cycle after the command is
// taken, with result (status, count, front entry after the command). The
// receiver cannot stall; result holds until the next command is taken.
// Throughput is one command per cycle. The entries sit in a row of DEPTH
// cells, front at cell 0. Every cell compares its pid against the key at
// once; a found flag ripples down the row, and each cell at or behind the
// first match loads its younger neighbor in the same edge.
// Reset clears the count and the result strobe; entry storage is not reset,
// only cells below the count are ever shown or matched.
// Push when full, pop or remove when empty, and remove with no match leave
// the queue as is and report their status. Command code 3 does nothing.
`default_nettype none
module fifo_queue_with_keyed_removal
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fqkr_pkg::in_word_t  request,
    output logic                     busy,
    output logic                     done,
    output fqkr_pkg::out_word_t      result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          done_reg;

    logic          take;
    logic          is_push;
    logic          is_pop;
    logic          is_remove;
    logic          empty;
    logic          full;

    fqkr_pkg::entry_t     new_entry;
    fqkr_pkg::entry_t     entries [DEPTH];
    fqkr_pkg::cell_ctrl_t ctrl    [DEPTH];
    logic [DEPTH:0]       found;

    // command path is never busy
    assign busy = 1'b0;
    assign take = start && !busy;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    assign is_push   = take && (request.cmd == fqkr_pkg::CMD_PUSH) && !full;
    assign is_pop    = take && (request.cmd == fqkr_pkg::CMD_POP) && !empty;
    assign is_remove = take && (request.cmd == fqkr_pkg::CMD_REMOVE) && !empty;

    assign new_entry.handle = request.job_handle;
    assign new_entry.pid    = request.job_pid;

    // found ripples from the front; found[DEPTH] says some held entry matched
    assign found[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign ctrl[gi].occupied = (CW'(gi) < count_reg);
            assign ctrl[gi].write    = is_push && (count_reg == CW'(gi));
            assign ctrl[gi].pop      = is_pop;
            assign ctrl[gi].remove   = is_remove;

            fqkr_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl[gi]),
                .new_entry (new_entry),
                .nbr_entry (entries[(gi + 1 < DEPTH) ? gi + 1 : gi]),
                .key       (request.job_pid),
                .found_in  (found[gi]),
                .entry     (entries[gi]),
                .found_out (found[gi + 1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = fqkr_pkg::ST_DONE;
        case (request.cmd)
            fqkr_pkg::CMD_PUSH:
            begin
                if (full)
                begin
                    status_next = fqkr_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            fqkr_pkg::CMD_POP:
            begin
                if (empty)
                begin
                    status_next = fqkr_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            fqkr_pkg::CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = fqkr_pkg::ST_EMPTY;
                end
                else if (found[DEPTH])
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = fqkr_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = fqkr_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= fqkr_pkg::ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= take;
            if (take)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    // result is read straight off the state registers after the update
    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.entry_count  = fqkr_pkg::COUNT_W'(count_reg);
    assign result.front_valid  = !empty;
    assign result.front_handle = empty ? '0 : entries[0].handle;
    assign result.front_pid    = empty ? '0 : entries[0].pid;

endmodule
`default_nettype wire
